>>> hdl/pru_pkg.sv
// ---------------------------------------------------------------------------
// pru_pkg
// shared types and constants of the pixel replication upscaler
// ---------------------------------------------------------------------------
package pru_pkg;

    localparam int DEF_MAX_WIDTH = 1024;
    localparam int DEF_MAX_SCALE = 16;

    localparam int COLOR_W = 8;
    localparam int PIXEL_W = 3 * COLOR_W;
    localparam int SCALE_W = 5;
    localparam int ROW_W   = 11;
    localparam int PAD_W   = 2;
    localparam int COPY_W  = 4;
    localparam int CFG_W   = ROW_W;

    // opcodes of an input word
    localparam logic OP_PIXEL  = 1'b0;
    localparam logic OP_REPLAY = 1'b1;

    // result status codes
    localparam logic ST_RUN    = 1'b0;
    localparam logic ST_REJECT = 1'b1;

    // configuration register indexes
    localparam logic CFG_SCALE = 1'b0;
    localparam logic CFG_WIDTH = 1'b1;

    // one result word in flight
    typedef struct packed {
        logic               status;
        logic               replay;
        logic [PIXEL_W-1:0] px;
        logic [SCALE_W-1:0] run;
        logic               row_end;
        logic [PAD_W-1:0]   pad;
        logic [COPY_W-1:0]  copy;
    } t_item;

endpackage

>>> hdl/pixel_replication_upscaler.sv
// ---------------------------------------------------------------------------
// pixel_replication_upscaler
// nearest-neighbor integer upscaler for a 24-bit raster, line buffer based
// ---------------------------------------------------------------------------
//  channel  | handshake                   | payload
//  ---------+-----------------------------+---------------------------------
//  input    | i_in_valid / o_in_ready     | i_opcode, i_blue/green/red_in
//  output   | o_out_valid / i_out_ready   | o_status, colors, o_run_length,
//           |                             | o_row_end, o_pad_bytes, o_copy_index
//  config   | i_cfg_we (no wait)          | i_cfg_index, i_cfg_data
//
//  one word per cycle sustained while the output is not stalled; a result
//  passes the line buffer read stage, then the output register
//  the line buffer port is touched at most once per word: write for a pixel,
//  read for a replay request, so the counters and the buffer never hold a word up
//  synchronous active-low reset clears counters, phase, valids and config registers
//  a stalled output keeps the buffer read data, since no read is issued
//  until the stage behind it moves on
// ---------------------------------------------------------------------------
module pixel_replication_upscaler #(
    parameter int MAX_WIDTH = pru_pkg::DEF_MAX_WIDTH,
    parameter int MAX_SCALE = pru_pkg::DEF_MAX_SCALE
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [pru_pkg::CFG_W-1:0]   i_cfg_data,
    // input words
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_opcode,
    input  logic [pru_pkg::COLOR_W-1:0] i_blue_in,
    input  logic [pru_pkg::COLOR_W-1:0] i_green_in,
    input  logic [pru_pkg::COLOR_W-1:0] i_red_in,
    // result words
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_status,
    output logic [pru_pkg::COLOR_W-1:0] o_blue_out,
    output logic [pru_pkg::COLOR_W-1:0] o_green_out,
    output logic [pru_pkg::COLOR_W-1:0] o_red_out,
    output logic [pru_pkg::SCALE_W-1:0] o_run_length,
    output logic                        o_row_end,
    output logic [pru_pkg::PAD_W-1:0]   o_pad_bytes,
    output logic [pru_pkg::COPY_W-1:0]  o_copy_index
);

    localparam int CW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int COLOR_W = pru_pkg::COLOR_W;
    localparam int SCALE_W = pru_pkg::SCALE_W;
    localparam int ROW_W   = pru_pkg::ROW_W;

    // config registers
    logic [SCALE_W-1:0] r_scale;
    logic [ROW_W-1:0]   r_width;

    // sequencing state
    logic [CW-1:0]      r_col,   n_col;
    logic [SCALE_W-1:0] r_copy,  n_copy;
    logic               r_replay, n_replay;

    // pipeline
    logic               r_s1_valid;
    pru_pkg::t_item     r_s1, n_s1;
    logic               r_out_valid;
    pru_pkg::t_item     r_out;

    // line buffer
    logic [pru_pkg::PIXEL_W-1:0] r_mem [0:MAX_WIDTH-1];
    logic [pru_pkg::PIXEL_W-1:0] r_mem_q;
    logic                        mem_wr, mem_rd;

    logic               accept, s2_load, op_ok, row_end;
    logic [SCALE_W-1:0] f_eff;
    logic [ROW_W-1:0]   w_eff;
    logic [pru_pkg::PAD_W-1:0] pad_mod;
    logic [pru_pkg::PIXEL_W-1:0] in_px;

    // ---- configuration ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_W'(1);
            r_width <= ROW_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pru_pkg::CFG_SCALE: r_scale <= i_cfg_data[SCALE_W-1:0];
                pru_pkg::CFG_WIDTH: r_width <= i_cfg_data[ROW_W-1:0];
                default:            r_scale <= r_scale;
            endcase
        end
    end

    // effective factor and width: zero acts as one, large values saturate
    always_comb begin
        if (r_scale == '0)
            f_eff = SCALE_W'(1);
        else if (32'(r_scale) > 32'(MAX_SCALE))
            f_eff = SCALE_W'(MAX_SCALE);
        else
            f_eff = r_scale;

        if (r_width == '0)
            w_eff = ROW_W'(1);
        else if (32'(r_width) > 32'(MAX_WIDTH))
            w_eff = ROW_W'(MAX_WIDTH);
        else
            w_eff = r_width;
    end

    // bmp row padding: only the low two bits of width and factor matter
    assign pad_mod = pru_pkg::PAD_W'(w_eff[1:0] * f_eff[1:0] * 2'd3);

    // ---- handshake ----
    assign s2_load    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s2_load;
    assign accept     = i_in_valid && o_in_ready;

    // ---- word decode and counter update ----
    assign op_ok   = (i_opcode == pru_pkg::OP_PIXEL) == !r_replay;
    assign row_end = (32'(r_col) + 32'd1) >= 32'(w_eff);
    assign in_px   = {i_red_in, i_green_in, i_blue_in};

    always_comb begin
        n_col    = r_col;
        n_copy   = r_copy;
        n_replay = r_replay;
        n_s1     = '0;
        mem_wr   = 1'b0;
        mem_rd   = 1'b0;

        if (!op_ok) begin
            // wrong kind for the phase: nothing moves
            n_s1.status = pru_pkg::ST_REJECT;
        end else begin
            n_s1.status  = pru_pkg::ST_RUN;
            n_s1.run     = f_eff;
            n_s1.row_end = row_end;
            n_s1.pad     = row_end ? pru_pkg::PAD_W'(2'd0 - pad_mod) : '0;
            if (i_opcode == pru_pkg::OP_PIXEL) begin
                // first pass: store and emit at once
                mem_wr   = accept;
                n_s1.px  = in_px;
                if (row_end) begin
                    n_col = '0;
                    if (f_eff > SCALE_W'(1)) begin
                        n_replay = 1'b1;
                        n_copy   = SCALE_W'(1);
                    end
                end else begin
                    n_col = CW'(32'(r_col) + 32'd1);
                end
            end else begin
                // replay: color is read from the line buffer and joins the word at the output register
                mem_rd      = accept;
                n_s1.replay = 1'b1;
                n_s1.copy   = r_copy[pru_pkg::COPY_W-1:0];
                if (row_end) begin
                    n_col = '0;
                    if (SCALE_W'(r_copy + SCALE_W'(1)) >= f_eff) begin
                        n_replay = 1'b0;
                        n_copy   = '0;
                    end else begin
                        n_copy = SCALE_W'(r_copy + SCALE_W'(1));
                    end
                end else begin
                    n_col = CW'(32'(r_col) + 32'd1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_copy   <= '0;
            r_replay <= 1'b0;
        end else if (accept) begin
            r_col    <= n_col;
            r_copy   <= n_copy;
            r_replay <= n_replay;
        end
    end

    // ---- line buffer, at most one port access per word ----
    always_ff @(posedge i_clk) begin
        if (mem_wr)
            r_mem[r_col] <= in_px;
        if (mem_rd)
            r_mem_q <= r_mem[r_col];
    end

    // ---- read stage ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s2_load) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept)
            r_s1 <= n_s1;
    end

    // ---- output register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load) begin
            r_out <= r_s1;
            // replay word picks up the buffered color
            if (r_s1.replay)
                r_out.px <= r_mem_q;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out.status;
    assign o_blue_out   = r_out.px[COLOR_W-1:0];
    assign o_green_out  = r_out.px[2*COLOR_W-1:COLOR_W];
    assign o_red_out    = r_out.px[3*COLOR_W-1:2*COLOR_W];
    assign o_run_length = r_out.run;
    assign o_row_end    = r_out.row_end;
    assign o_pad_bytes  = r_out.pad;
    assign o_copy_index = r_out.copy;

    // ---- assertions ----
    a_reject_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status == pru_pkg::ST_REJECT
        |-> r_out.run == '0 && !r_out.row_end && r_out.px == '0)
        else $error("rejected word carries a run");

    a_pad_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.pad != '0 |-> r_out.row_end)
        else $error("padding outside row end");

    a_copy_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_replay |-> r_copy != '0) and (!r_replay |-> r_copy == '0))
        else $error("copy count out of step with phase");

    a_pixel_in_replay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && r_replay && i_opcode == pru_pkg::OP_PIXEL
        |=> r_s1_valid && r_s1.status == pru_pkg::ST_REJECT && $stable(r_replay))
        else $error("pixel during replay not rejected");

    a_no_access_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s2_load |-> !mem_rd && !mem_wr)
        else $error("line buffer touched while read stage stalls");

endmodule

>>> dv/tb_pixel_replication_upscaler.sv
// ---------------------------------------------------------------------------
// tb_pixel_replication_upscaler
// self-checking bench for the nearest-neighbor integer upscaler: a behavioral
// model of the line buffer, counters and replay phase predicts every run
// word, which is compared field by field with what leaves the block, under
// random input gaps, output stalls and register settings
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_pixel_replication_upscaler;

    localparam int DEF_MAX_WIDTH = pru_pkg::DEF_MAX_WIDTH;
    localparam int DEF_MAX_SCALE = pru_pkg::DEF_MAX_SCALE;
    localparam int COLOR_W       = pru_pkg::COLOR_W;
    localparam int PIXEL_W       = pru_pkg::PIXEL_W;
    localparam int SCALE_W       = pru_pkg::SCALE_W;
    localparam int ROW_W         = pru_pkg::ROW_W;
    localparam int PAD_W         = pru_pkg::PAD_W;
    localparam int COPY_W        = pru_pkg::COPY_W;
    localparam int CFG_W         = pru_pkg::CFG_W;

    // cycles with no handshake or register write before the run is declared hung
    localparam int WATCHDOG_LIMIT = 2000;

    // one expected run word
    typedef struct {
        logic               status;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
        logic [SCALE_W-1:0] run_len;
        logic               row_end;
        logic [PAD_W-1:0]   pad;
        logic [COPY_W-1:0]  copy;
    } t_run_word;

    // every block input known from time zero
    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_we    = 1'b0;
    logic                i_cfg_index = pru_pkg::CFG_SCALE;
    logic [CFG_W-1:0]    i_cfg_data  = '0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    logic                i_opcode    = pru_pkg::OP_PIXEL;
    logic [COLOR_W-1:0]  i_blue_in   = '0;
    logic [COLOR_W-1:0]  i_green_in  = '0;
    logic [COLOR_W-1:0]  i_red_in    = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b1;
    logic                o_status;
    logic [COLOR_W-1:0]  o_blue_out;
    logic [COLOR_W-1:0]  o_green_out;
    logic [COLOR_W-1:0]  o_red_out;
    logic [SCALE_W-1:0]  o_run_length;
    logic                o_row_end;
    logic [PAD_W-1:0]    o_pad_bytes;
    logic [COPY_W-1:0]   o_copy_index;

    // model state: line buffer, counters, phase and register copies
    logic [PIXEL_W-1:0]  row_pixels [DEF_MAX_WIDTH];
    bit                  pix_written [DEF_MAX_WIDTH];
    int                  col_pos;
    int                  copy_pos;
    bit                  in_replay;
    logic [SCALE_W-1:0]  cfg_scale;
    logic [ROW_W-1:0]    cfg_width;

    // run words predicted and not yet seen at the output
    t_run_word           pending_runs[$];

    int                  err_count     = 0;
    int                  runs_seen     = 0;
    int                  quiet_cycles  = 0;
    // idling knobs: chance out of ten that a burst starts, zero for none
    int                  idle_rate     = 0;
    int                  out_idle_rate = 0;
    int                  stall_left    = 0;
    // set for the tail of the run: no idling on either side
    bit                  calm          = 1'b0;

    pixel_replication_upscaler i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_blue_in    (i_blue_in),
        .i_green_in   (i_green_in),
        .i_red_in     (i_red_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_blue_out   (o_blue_out),
        .o_green_out  (o_green_out),
        .o_red_out    (o_red_out),
        .o_run_length (o_run_length),
        .o_row_end    (o_row_end),
        .o_pad_bytes  (o_pad_bytes),
        .o_copy_index (o_copy_index)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // model helpers
    // ---------------------------------------------------------------------

    // factor 0 acts as 1, above the maximum it saturates
    function automatic int factor_of(logic [SCALE_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > DEF_MAX_SCALE)
            return DEF_MAX_SCALE;
        return int'(v);
    endfunction

    // same clamping for the row width
    function automatic int width_of(logic [ROW_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > DEF_MAX_WIDTH)
            return DEF_MAX_WIDTH;
        return int'(v);
    endfunction

    // takes one accepted input word, advances the model, returns its run word
    function automatic t_run_word predict_run(logic op, logic [COLOR_W-1:0] b,
                                              logic [COLOR_W-1:0] g,
                                              logic [COLOR_W-1:0] r);
        t_run_word res;
        int        f;
        int        w;
        int        col;
        bit        last;
        f   = factor_of(cfg_scale);
        w   = width_of(cfg_width);
        col = col_pos;
        if (col >= DEF_MAX_WIDTH)
            col = DEF_MAX_WIDTH - 1;
        res = '{default: '0};
        // wrong kind of word for the phase: rejected, state untouched
        if ((op == pru_pkg::OP_PIXEL) == in_replay) begin
            res.status = pru_pkg::ST_REJECT;
            return res;
        end
        last        = (col + 1 >= w);
        res.status  = pru_pkg::ST_RUN;
        res.run_len = SCALE_W'(f);
        res.row_end = last;
        res.pad     = last ? PAD_W'((4 - (w * f * 3) % 4) % 4) : '0;
        if (op == pru_pkg::OP_PIXEL) begin
            row_pixels[col]  = {r, g, b};
            pix_written[col] = 1'b1;
            {res.red, res.green, res.blue} = {r, g, b};
            res.copy = '0;
            if (last) begin
                col_pos = 0;
                if (f > 1) begin
                    in_replay = 1'b1;
                    copy_pos  = 1;
                end
            end else begin
                col_pos = col + 1;
            end
        end else begin
            {res.red, res.green, res.blue} = row_pixels[col];
            res.copy = COPY_W'(copy_pos);
            if (last) begin
                col_pos  = 0;
                copy_pos = copy_pos + 1;
                if (copy_pos >= f) begin
                    in_replay = 1'b0;
                    copy_pos  = 0;
                end
            end else begin
                col_pos = col + 1;
            end
        end
        return res;
    endfunction

    // a wider row during replay must only reach buffer entries already written
    function automatic bit width_ok(int v);
        int w;
        w = width_of(ROW_W'(v));
        if (!in_replay)
            return 1'b1;
        for (int i = 0; i < w; i++)
            if (!pix_written[i])
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic report_error(input string msg);
        err_count++;
        $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want)
            report_error($sformatf("run word %0d %s got %0d expected %0d",
                                   runs_seen, name, got, want));
    endtask

    // ---------------------------------------------------------------------
    // monitor: sampled at the rising edge, before the block updates
    // config writes and accepted input words feed the model, accepted
    // output words are checked against the oldest prediction
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin : score
        t_run_word want;
        if (!i_rst_n) begin
            col_pos   = 0;
            copy_pos  = 0;
            in_replay = 1'b0;
            cfg_scale = SCALE_W'(1);
            cfg_width = ROW_W'(1);
            for (int i = 0; i < DEF_MAX_WIDTH; i++)
                pix_written[i] = 1'b0;
            pending_runs.delete();
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pending_runs.size() == 0) begin
                    report_error("run word with nothing expected");
                end else begin
                    want = pending_runs.pop_front();
                    compare_field("status",     o_status,     want.status);
                    compare_field("blue",       o_blue_out,   want.blue);
                    compare_field("green",      o_green_out,  want.green);
                    compare_field("red",        o_red_out,    want.red);
                    compare_field("run_length", o_run_length, want.run_len);
                    compare_field("row_end",    o_row_end,    want.row_end);
                    compare_field("pad_bytes",  o_pad_bytes,  want.pad);
                    compare_field("copy_index", o_copy_index, want.copy);
                end
                runs_seen++;
            end
            if (i_cfg_we) begin
                if (i_cfg_index == pru_pkg::CFG_SCALE)
                    cfg_scale = i_cfg_data[SCALE_W-1:0];
                else
                    cfg_width = i_cfg_data[ROW_W-1:0];
            end
            if (i_in_valid && o_in_ready)
                pending_runs.push_back(predict_run(i_opcode, i_blue_in,
                                                   i_green_in, i_red_in));
        end
    end

    // watchdog: any handshake or register write counts as progress
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && o_in_ready) ||
            (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t ns: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("tb_pixel_replication_upscaler: done, errors");
                $finish;
            end
        end
    end

    // output side: ready drops in bursts of random length
    always @(negedge i_clk) begin
        if (calm || out_idle_rate == 0) begin
            stall_left  = 0;
            i_out_ready = 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            i_out_ready = 1'b0;
        end else if ($urandom_range(0, 9) < out_idle_rate) begin
            stall_left  = $urandom_range(1, 12) - 1;
            i_out_ready = 1'b0;
        end else begin
            i_out_ready = 1'b1;
        end
    end

    // ---------------------------------------------------------------------
    // stimulus tasks, all driving at the falling edge
    // ---------------------------------------------------------------------

    // register write, only called with nothing in flight
    task automatic write_reg(input logic idx, input int value);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = CFG_W'(value);
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // sender pauses until every predicted run word has come out
    task automatic drain_runs();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_runs.size() != 0)
            @(negedge i_clk);
    endtask

    // optional idle burst of random length, called at a falling edge
    task automatic sender_gap();
        int gap;
        if (!calm && idle_rate != 0 && $urandom_range(0, 9) < idle_rate) begin
            gap        = $urandom_range(1, 12);
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // present one word and hold it until it is taken
    task automatic put_word(input logic op, input logic [COLOR_W-1:0] b,
                            input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] r);
        i_in_valid = 1'b1;
        i_opcode   = op;
        i_blue_in  = b;
        i_green_in = g;
        i_red_in   = r;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
    endtask

    // directed word
    task automatic send_word(input logic op, input logic [COLOR_W-1:0] b,
                             input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] r);
        @(negedge i_clk);
        sender_gap();
        put_word(op, b, g, r);
    endtask

    // random word: the kind that fits the phase, legal_pct percent of the time
    task automatic send_next(input int legal_pct);
        logic op;
        @(negedge i_clk);
        sender_gap();
        op = in_replay ? pru_pkg::OP_REPLAY : pru_pkg::OP_PIXEL;
        if ($urandom_range(0, 99) >= legal_pct)
            op = ~op;
        put_word(op, COLOR_W'($urandom_range(0, 255)), COLOR_W'($urandom_range(0, 255)),
                 COLOR_W'($urandom_range(0, 255)));
    endtask

    // ---------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------

    // reset settings: factor 1, one pixel per row, every pixel ends a row
    task automatic test_reset_state();
        idle_rate     = 3;
        out_idle_rate = 3;
        send_word(pru_pkg::OP_PIXEL,  8'h00, 8'h00, 8'h00);
        send_word(pru_pkg::OP_PIXEL,  8'hff, 8'hff, 8'hff);
        // no replay phase at factor 1, so a replay request is rejected
        send_word(pru_pkg::OP_REPLAY, 8'h12, 8'h34, 8'h56);
        drain_runs();
    endtask

    // one row of three at factor 2, with a wrong-kind word in each phase
    task automatic test_replay_rows();
        write_reg(pru_pkg::CFG_SCALE, 2);
        write_reg(pru_pkg::CFG_WIDTH, 3);
        send_word(pru_pkg::OP_PIXEL,  8'hff, 8'hff, 8'hff);
        send_word(pru_pkg::OP_PIXEL,  8'h00, 8'h00, 8'h00);
        send_word(pru_pkg::OP_PIXEL,  8'h55, 8'haa, 8'h55);
        // pixel while replaying
        send_word(pru_pkg::OP_PIXEL,  8'ha5, 8'h5a, 8'hc3);
        repeat (3) send_word(pru_pkg::OP_REPLAY, 8'hff, 8'h00, 8'hff);
        // replay request back in the first pass
        send_word(pru_pkg::OP_REPLAY, 8'h00, 8'hff, 8'h00);
        drain_runs();
    endtask

    // register values outside the range: zero acts as one, large saturates
    task automatic test_range_limits();
        write_reg(pru_pkg::CFG_SCALE, 0);
        write_reg(pru_pkg::CFG_WIDTH, 0);
        send_word(pru_pkg::OP_PIXEL, 8'h81, 8'h42, 8'h24);
        drain_runs();
        // factor 31 acts as 16: one pixel, then copies 1 through 15
        write_reg(pru_pkg::CFG_SCALE, 31);
        write_reg(pru_pkg::CFG_WIDTH, 1);
        send_word(pru_pkg::OP_PIXEL, 8'hc0, 8'hde, 8'h7f);
        repeat (15) send_word(pru_pkg::OP_REPLAY, 8'hff, 8'hff, 8'hff);
        drain_runs();
    endtask

    // width above the buffer size saturates: one full-width row
    task automatic test_wide_rows();
        idle_rate     = 2;
        out_idle_rate = 2;
        write_reg(pru_pkg::CFG_SCALE, 1);
        write_reg(pru_pkg::CFG_WIDTH, 2047);
        repeat (DEF_MAX_WIDTH) send_next(100);
        drain_runs();
    endtask

    // random phases, settings often renewed between them, mostly well-formed rows
    task automatic test_random_traffic(input int total);
        int sent;
        int burst;
        int legal_pct;
        int v;
        sent = 0;
        while (sent < total) begin
            // phase boundary: nothing in flight, often mid-row
            drain_runs();
            calm = (sent >= total * 4 / 5);
            if ($urandom_range(0, 3) != 0) begin
                v = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                                : $urandom_range(1, 6);
                write_reg(pru_pkg::CFG_SCALE, v);
            end
            if ($urandom_range(0, 3) != 0) begin
                v = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 80)
                                                : $urandom_range(1, 12);
                if (width_ok(v))
                    write_reg(pru_pkg::CFG_WIDTH, v);
            end
            idle_rate     = $urandom_range(0, 4);
            out_idle_rate = $urandom_range(0, 4);
            // now and then a noisy phase with many wrong-kind words
            legal_pct = ($urandom_range(0, 4) == 0) ? 50 : 92;
            burst     = $urandom_range(10, 100);
            repeat (burst) send_next(legal_pct);
            sent += burst;
        end
        drain_runs();
    endtask

    // ---------------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_replay_rows();
        test_range_limits();
        test_wide_rows();
        test_random_traffic(650);

        // settle: wait for every result to leave the block
        calm = 1'b1;
        drain_runs();
        repeat (24) @(negedge i_clk);
        if (pending_runs.size() != 0)
            report_error($sformatf("%0d run words never came out", pending_runs.size()));

        if (err_count == 0)
            $display("tb_pixel_replication_upscaler: done, clean");
        else
            $display("tb_pixel_replication_upscaler: done, errors");
        $finish;
    end

endmodule
